// ===== rtl/bcs_pkg.sv =====
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared types and constants for the box collision search block.
// ----------------------------------------------------------------------------
package bcs_pkg;

    localparam int ENTRY_COUNT = 64;
    localparam int ENTRY_AW    = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    // slave-side tdata: index, pos_x, pos_y, width, height, page_col, page_row, solid
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 3;   // op, kind
    // master-side tdata: hit_index, overlap_x, overlap_y
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;   // hit, kind_echo

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOVER,
        ST_SCAN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic        [11:0] h;
        logic        [11:0] w;
        logic signed [7:0]  row;
        logic signed [7:0]  col;
    } t_entry;

    typedef struct packed {
        logic take;        // item accepted this cycle
        logic scan_start;  // mover data valid: latch it and read entry 0
        logic scan_next;   // read the entry after the one being compared
        logic load_hit;    // capture hit fields into the pending result
        logic push;        // move pending result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic is_query;
        logic mover_ok;
        logic cmp_hit;
        logic cmp_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/bcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcs_ctrl
// Sequencer: accepts an item, walks the table scan for a query with a solid mover, hands off the result.
// ----------------------------------------------------------------------------
module bcs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  bcs_pkg::t_dp_sts i_sts,
    output bcs_pkg::t_dp_cmd o_cmd
);
    import bcs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.is_query && i_sts.mover_ok) begin
                        n_state = ST_MOVER;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_MOVER: begin
                o_cmd.scan_start = 1'b1;
                n_state          = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.cmp_hit) begin
                    o_cmd.load_hit = 1'b1;
                    n_state        = ST_RESULT;
                end else if (i_sts.cmp_last) begin
                    n_state = ST_RESULT;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/bcs_dpath.sv =====
// ----------------------------------------------------------------------------
// bcs_dpath
// Entry table, solid flags, mover registers, overlap compare, result registers.
// ----------------------------------------------------------------------------
module bcs_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bcs_pkg::S_TDATA_W-1:0] i_s_tdata,  // index, pos_x, pos_y, width,
                                                      // height, page_col, page_row, solid
    input  logic [bcs_pkg::S_TUSER_W-1:0] i_s_tuser,  // op, kind
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [bcs_pkg::M_TDATA_W-1:0] o_m_tdata,  // hit_index, overlap_x, overlap_y
    output logic [bcs_pkg::M_TUSER_W-1:0] o_m_tuser,  // hit, kind_echo
    input  bcs_pkg::t_dp_cmd              i_cmd,
    output bcs_pkg::t_dp_sts              o_sts
);
    import bcs_pkg::*;

    // input unpacking
    logic [5:0]  in_index;
    t_entry      in_entry;
    logic        in_solid;
    logic        in_op;
    logic [1:0]  in_kind;
    logic        in_range;
    logic [ENTRY_AW-1:0] in_addr;

    assign in_index       = i_s_tdata[5:0];
    assign in_entry.x     = i_s_tdata[21:6];
    assign in_entry.y     = i_s_tdata[37:22];
    assign in_entry.w     = i_s_tdata[49:38];
    assign in_entry.h     = i_s_tdata[61:50];
    assign in_entry.col   = i_s_tdata[69:62];
    assign in_entry.row   = i_s_tdata[77:70];
    assign in_solid       = i_s_tdata[78];
    assign in_op          = i_s_tuser[0];
    assign in_kind        = i_s_tuser[2:1];
    assign in_range       = (32'(in_index) < ENTRY_COUNT);
    assign in_addr        = ENTRY_AW'(in_index);

    // entry table and solid flags
    t_entry              r_mem [ENTRY_COUNT];
    t_entry              r_rd_data;
    logic [ENTRY_AW-1:0] r_cmp_idx;
    logic [ENTRY_AW-1:0] rd_addr;
    logic [ENTRY_COUNT-1:0] r_solid;
    logic                wr_en;

    assign wr_en = i_cmd.take && (in_op == OP_WRITE) && in_range;

    always_comb begin
        if (i_cmd.take) begin
            rd_addr = in_addr;
        end else if (i_cmd.scan_start) begin
            rd_addr = '0;
        end else if (i_cmd.scan_next) begin
            rd_addr = r_cmp_idx + ENTRY_AW'(1);
        end else begin
            rd_addr = r_cmp_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[in_addr] <= in_entry;
        end
        r_rd_data <= r_mem[rd_addr];
        r_cmp_idx <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_solid <= '0;
        end else if (wr_en) begin
            r_solid[in_addr] <= in_solid;
        end
    end

    // query and mover registers
    logic signed [15:0]  r_dx;
    logic signed [15:0]  r_dy;
    logic [ENTRY_AW-1:0] r_mover_idx;
    logic signed [16:0]  r_mx;
    logic signed [16:0]  r_my;
    logic signed [17:0]  r_mxe;
    logic signed [17:0]  r_mye;
    logic signed [7:0]   r_mcol;
    logic signed [7:0]   r_mrow;
    logic signed [16:0]  n_mx;
    logic signed [16:0]  n_my;

    assign n_mx = {r_rd_data.x[15], r_rd_data.x} + {r_dx[15], r_dx};
    assign n_my = {r_rd_data.y[15], r_rd_data.y} + {r_dy[15], r_dy};

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_dx        <= in_entry.x;
            r_dy        <= in_entry.y;
            r_mover_idx <= in_addr;
        end
        if (i_cmd.scan_start) begin
            r_mx   <= n_mx;
            r_my   <= n_my;
            r_mxe  <= {n_mx[16], n_mx} + {6'b0, r_rd_data.w};
            r_mye  <= {n_my[16], n_my} + {6'b0, r_rd_data.h};
            r_mcol <= r_rd_data.col;
            r_mrow <= r_rd_data.row;
        end
    end

    // candidate compare
    logic signed [17:0] mx18;
    logic signed [17:0] my18;
    logic signed [17:0] bx18;
    logic signed [17:0] by18;
    logic signed [17:0] bxw;
    logic signed [17:0] byh;
    logic signed [17:0] ox;
    logic signed [17:0] oy;
    logic signed [8:0]  dcol;
    logic signed [8:0]  drow;
    logic               page_ok;
    logic               ovl_x;
    logic               ovl_y;

    assign mx18 = {r_mx[16], r_mx};
    assign my18 = {r_my[16], r_my};
    assign bx18 = {{2{r_rd_data.x[15]}}, r_rd_data.x};
    assign by18 = {{2{r_rd_data.y[15]}}, r_rd_data.y};
    assign bxw  = bx18 + {6'b0, r_rd_data.w};
    assign byh  = by18 + {6'b0, r_rd_data.h};
    assign ox   = mx18 - bx18;
    assign oy   = my18 - by18;
    assign dcol = {r_rd_data.col[7], r_rd_data.col} - {r_mcol[7], r_mcol};
    assign drow = {r_rd_data.row[7], r_rd_data.row} - {r_mrow[7], r_mrow};

    // page distance at most one on both axes
    assign page_ok = (dcol >= -9'sd1) && (dcol <= 9'sd1) && (drow >= -9'sd1) && (drow <= 9'sd1);
    // ox < w and ox + mw > 0, same in y
    assign ovl_x   = (mx18 < bxw) && (r_mxe > bx18);
    assign ovl_y   = (my18 < byh) && (r_mye > by18);

    assign o_sts.is_query = (in_op == OP_QUERY);
    assign o_sts.mover_ok = in_range && r_solid[in_addr];
    assign o_sts.cmp_hit  = (r_cmp_idx != r_mover_idx) && r_solid[r_cmp_idx]
                            && page_ok && ovl_x && ovl_y;
    assign o_sts.cmp_last = (r_cmp_idx == ENTRY_AW'(ENTRY_COUNT - 1));
    assign o_sts.out_free = !o_m_tvalid || i_m_tready;

    // pending result and output register
    logic               r_res_hit;
    logic [5:0]         r_res_idx;
    logic signed [12:0] r_res_ox;
    logic signed [12:0] r_res_oy;
    logic [1:0]         r_res_kind;
    logic               r_out_valid;
    logic               r_out_hit;
    logic [5:0]         r_out_idx;
    logic signed [12:0] r_out_ox;
    logic signed [12:0] r_out_oy;
    logic [1:0]         r_out_kind;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_res_hit  <= 1'b0;
            r_res_idx  <= '0;
            r_res_ox   <= '0;
            r_res_oy   <= '0;
            r_res_kind <= (in_op == OP_QUERY) ? in_kind : 2'b0;
        end else if (i_cmd.load_hit) begin
            r_res_hit <= 1'b1;
            r_res_idx <= 6'(r_cmp_idx);
            r_res_ox  <= ox[12:0];
            r_res_oy  <= oy[12:0];
        end
        if (i_cmd.push) begin
            r_out_hit  <= r_res_hit;
            r_out_idx  <= r_res_idx;
            r_out_ox   <= r_res_ox;
            r_out_oy   <= r_res_oy;
            r_out_kind <= r_res_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_oy, r_out_ox, r_out_idx};
    assign o_m_tuser  = {r_out_kind, r_out_hit};

endmodule

// ===== rtl/box_collision_search.sv =====
// A write, or a query whose mover is out of range or not solid, goes from the take
// state to the result state; other queries read the mover entry, then scan the table
// to the first hit or the last entry. No new item is taken until the result has been
// pushed into the output register; the single table read port feeds one compared entry per cycle.
// Reset (synchronous, active low) clears the solid flags and the output valid;
// the table contents are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// box_collision_search
// Box table with a first-hit overlap search for a displaced mover entry.
// ----------------------------------------------------------------------------
module box_collision_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [bcs_pkg::S_TDATA_W-1:0] i_s_tdata,  // index, pos_x, pos_y, width,
                                                      // height, page_col, page_row, solid
    input  logic [bcs_pkg::S_TUSER_W-1:0] i_s_tuser,  // op, kind
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [bcs_pkg::M_TDATA_W-1:0] o_m_tdata,  // hit_index, overlap_x, overlap_y
    output logic [bcs_pkg::M_TUSER_W-1:0] o_m_tuser   // hit, kind_echo
);
    import bcs_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    bcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bcs_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule
